// ===== design/epp_pkg.sv =====
// Shared constants and types for the eye point projection block.
// No dependencies; used by epp_div and eye_point_projection.
package epp_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int COEF_BITS_DEF  = 16;

    localparam int OUT_BITS      = 24;
    localparam int PD_BITS       = 24;
    localparam int SCR_BITS      = 13;
    localparam int COL_BITS      = 48;
    localparam int EYE_BITS      = 60;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 60;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_X  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_Y  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_Z  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EYE    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCR_W  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCR_H  = 3'd6;

    localparam logic [COL_BITS-1:0] ROT_X_RST = 48'h0000_0000_4000;
    localparam logic [COL_BITS-1:0] ROT_Y_RST = 48'h0000_4000_0000;
    localparam logic [COL_BITS-1:0] ROT_Z_RST = 48'h4000_0000_0000;
    localparam logic [SCR_BITS-1:0] SCR_W_RST = 13'd640;
    localparam logic [SCR_BITS-1:0] SCR_H_RST = 13'd480;

    localparam logic signed [OUT_BITS-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = -24'sh800000;

    // sideband that rides along the divider
    typedef struct packed {
        logic behind;
        logic neg_x;
        logic neg_y;
    } meta_t;

endpackage

// ===== design/epp_div.sv =====
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Depends on epp_pkg (meta_t, PD_BITS).
module epp_div #(
    parameter int MW  = 25,
    parameter int DVW = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  epp_pkg::meta_t       in_meta,
    input  logic [MW+epp_pkg::PD_BITS-1:0] num_x,
    input  logic [MW+epp_pkg::PD_BITS-1:0] num_y,
    input  logic [DVW-1:0]       divisor,
    output logic                 out_valid,
    output epp_pkg::meta_t       out_meta,
    output logic [MW-1:0]        quot_x,
    output logic [MW-1:0]        quot_y
);

    logic [DVW-1:0]     rx_reg [1:MW];
    logic [DVW-1:0]     ry_reg [1:MW];
    logic [DVW-1:0]     dv_reg [1:MW];
    logic [MW-1:0]      lx_reg [1:MW];
    logic [MW-1:0]      ly_reg [1:MW];
    logic [MW-1:0]      qx_reg [1:MW];
    logic [MW-1:0]      qy_reg [1:MW];
    epp_pkg::meta_t     mt_reg [1:MW];
    logic [MW:1]        vld_reg;

    for (genvar k = 1; k <= MW; k++) begin : g_stage
        logic [DVW-1:0] prx, pry, pdv;
        logic [MW-1:0]  plx, ply, pqx, pqy;
        logic           pv;
        epp_pkg::meta_t pm;
        logic [DVW:0]   tx, ty, dx, dy;
        logic           gx, gy;

        if (k == 1) begin : g_first
            // quotient fits MW bits, so the upper part is already below the divisor
            assign prx = DVW'(num_x >> MW);
            assign pry = DVW'(num_y >> MW);
            assign plx = num_x[MW-1:0];
            assign ply = num_y[MW-1:0];
            assign pqx = '0;
            assign pqy = '0;
            assign pdv = divisor;
            assign pv  = in_valid;
            assign pm  = in_meta;
        end else begin : g_rest
            assign prx = rx_reg[k-1];
            assign pry = ry_reg[k-1];
            assign plx = lx_reg[k-1];
            assign ply = ly_reg[k-1];
            assign pqx = qx_reg[k-1];
            assign pqy = qy_reg[k-1];
            assign pdv = dv_reg[k-1];
            assign pv  = vld_reg[k-1];
            assign pm  = mt_reg[k-1];
        end

        assign tx = {prx, plx[MW-1]};
        assign ty = {pry, ply[MW-1]};
        assign gx = tx >= {1'b0, pdv};
        assign gy = ty >= {1'b0, pdv};
        assign dx = tx - {1'b0, pdv};
        assign dy = ty - {1'b0, pdv};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= pv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rx_reg[k] <= gx ? dx[DVW-1:0] : tx[DVW-1:0];
                ry_reg[k] <= gy ? dy[DVW-1:0] : ty[DVW-1:0];
                lx_reg[k] <= plx << 1;
                ly_reg[k] <= ply << 1;
                qx_reg[k] <= {pqx[MW-2:0], gx};
                qy_reg[k] <= {pqy[MW-2:0], gy};
                dv_reg[k] <= pdv;
                mt_reg[k] <= pm;
            end
        end
    end

    assign out_valid = vld_reg[MW];
    assign out_meta  = mt_reg[MW];
    assign quot_x    = qx_reg[MW];
    assign quot_y    = qy_reg[MW];

endmodule

// ===== design/eye_point_projection.sv =====
// Top level of the eye point projection pipeline.
// Depends on epp_pkg and epp_div.
//
// Usage: points enter on s_valid/s_ready (s_point_x/y/z, signed Q16.4) and
// leave on m_valid/m_ready as m_status, m_screen_x, m_screen_y. One result
// per point, in order. Configuration is a plain write port (cfg_we,
// cfg_index, cfg_wdata) and may only be written while the pipe is empty.
// The pipeline has five arithmetic stages (offset, products, dot sums,
// range check, scale multiply), one divider stage per quotient bit
// (COORD_BITS + 5 of them), then the output register. Throughput is one
// point per clock while the receiver does not stall; the divider pipeline
// sets the latency, not the rate.
// Reset clears all valid bits and loads the identity matrix, eye at the
// origin, plane distance 0 and a 640 x 480 screen.
// When the receiver stalls, one result parks in a skid register and the
// whole pipe freezes the cycle after; s_ready drops until the skid empties.
module eye_point_projection #(
    parameter int COORD_BITS = epp_pkg::COORD_BITS_DEF,
    parameter int COEF_BITS  = epp_pkg::COEF_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [COORD_BITS-1:0]           s_point_x,
    input  logic signed [COORD_BITS-1:0]           s_point_y,
    input  logic signed [COORD_BITS-1:0]           s_point_z,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_status,
    output logic signed [epp_pkg::OUT_BITS-1:0]    m_screen_x,
    output logic signed [epp_pkg::OUT_BITS-1:0]    m_screen_y,
    input  logic                                   cfg_we,
    input  logic [epp_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [epp_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = COEF_BITS + DW;
    localparam int SHW = DW + 2;
    localparam int VW  = DW + 4;
    localparam int MW  = VW;
    localparam int NW  = MW + epp_pkg::PD_BITS;
    localparam int CW  = ((VW > epp_pkg::PD_BITS) ? VW : epp_pkg::PD_BITS) + 2;
    localparam int SW  = MW + 2;
    localparam int XW  = ((SW > epp_pkg::OUT_BITS) ? SW : epp_pkg::OUT_BITS) + 1;
    localparam int KW  = 3 * COEF_BITS;
    localparam int EW  = 3 * COORD_BITS;

    // configuration
    logic [epp_pkg::COL_BITS-1:0] rot_x_reg, rot_y_reg, rot_z_reg;
    logic [epp_pkg::EYE_BITS-1:0] eye_reg;
    logic [epp_pkg::PD_BITS-1:0]  pd_reg;
    logic [epp_pkg::SCR_BITS-1:0] scr_w_reg, scr_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_x_reg <= epp_pkg::ROT_X_RST;
            rot_y_reg <= epp_pkg::ROT_Y_RST;
            rot_z_reg <= epp_pkg::ROT_Z_RST;
            eye_reg   <= '0;
            pd_reg    <= '0;
            scr_w_reg <= epp_pkg::SCR_W_RST;
            scr_h_reg <= epp_pkg::SCR_H_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                epp_pkg::CFG_ROT_X: rot_x_reg <= cfg_wdata[epp_pkg::COL_BITS-1:0];
                epp_pkg::CFG_ROT_Y: rot_y_reg <= cfg_wdata[epp_pkg::COL_BITS-1:0];
                epp_pkg::CFG_ROT_Z: rot_z_reg <= cfg_wdata[epp_pkg::COL_BITS-1:0];
                epp_pkg::CFG_EYE:   eye_reg   <= cfg_wdata[epp_pkg::EYE_BITS-1:0];
                epp_pkg::CFG_PLANE: pd_reg    <= cfg_wdata[epp_pkg::PD_BITS-1:0];
                epp_pkg::CFG_SCR_W: scr_w_reg <= cfg_wdata[epp_pkg::SCR_BITS-1:0];
                epp_pkg::CFG_SCR_H: scr_h_reg <= cfg_wdata[epp_pkg::SCR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // fields past the packed register width read as zero
    logic [KW-1:0] colx, coly, colz;
    logic [EW-1:0] eye_ext;
    assign colx    = KW'(rot_x_reg);
    assign coly    = KW'(rot_y_reg);
    assign colz    = KW'(rot_z_reg);
    assign eye_ext = EW'(eye_reg);

    logic signed [COEF_BITS-1:0] coef [0:8];
    for (genvar j = 0; j < 3; j++) begin : g_coef
        assign coef[j]     = colx[j*COEF_BITS +: COEF_BITS];
        assign coef[3 + j] = coly[j*COEF_BITS +: COEF_BITS];
        assign coef[6 + j] = colz[j*COEF_BITS +: COEF_BITS];
    end

    logic en;
    logic skid_full_reg;
    assign en      = !skid_full_reg;
    assign s_ready = !skid_full_reg;

    // stage 1: offset from the eye
    logic                 v1_reg;
    logic signed [DW-1:0] d_reg [0:2];
    logic signed [COORD_BITS-1:0] pin [0:2];
    assign pin[0] = s_point_x;
    assign pin[1] = s_point_y;
    assign pin[2] = s_point_z;

    // stage 2: the nine products
    logic                 v2_reg;
    logic signed [PW-1:0] p_reg [0:8];

    // stage 3: dot sums
    logic                 v3_reg;
    logic signed [VW-1:0] vx_reg, vy_reg, vz_reg;
    logic signed [SHW-1:0] sh [0:8];

    for (genvar i = 0; i < 9; i++) begin : g_sh
        logic signed [PW-1:0] shf;
        assign shf   = p_reg[i] >>> (COEF_BITS - 2);
        assign sh[i] = shf[SHW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= DW'(pin[i]) -
                            DW'($signed(eye_ext[i*COORD_BITS +: COORD_BITS]));
            end
            for (int i = 0; i < 9; i++) begin
                p_reg[i] <= PW'(coef[i]) * PW'(d_reg[i % 3]);
            end
            vx_reg <= VW'(sh[0]) + VW'(sh[1]) + VW'(sh[2]);
            vy_reg <= VW'(sh[3]) + VW'(sh[4]) + VW'(sh[5]);
            vz_reg <= VW'(sh[6]) + VW'(sh[7]) + VW'(sh[8]);
        end
    end

    // stage 4: plane test, magnitudes
    logic                 v4_reg;
    epp_pkg::meta_t       m4_reg;
    logic [MW-1:0]        mx_reg, my_reg;
    logic [VW-1:0]        dv4_reg;
    logic                 behind;
    logic signed [CW-1:0] vz_w, pd_w;

    assign vz_w   = CW'(vz_reg);
    assign pd_w   = CW'($signed({1'b0, pd_reg}));
    assign behind = (vz_w <= 0) || (pd_w >= vz_w);

    // stage 5: numerators
    logic                 v5_reg;
    epp_pkg::meta_t       m5_reg;
    logic [NW-1:0]        nx_reg, ny_reg;
    logic [VW-1:0]        dv5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m4_reg.behind <= behind;
            m4_reg.neg_x  <= vx_reg[VW-1];
            m4_reg.neg_y  <= vy_reg[VW-1];
            mx_reg  <= vx_reg[VW-1] ? MW'(-vx_reg) : MW'(vx_reg);
            my_reg  <= vy_reg[VW-1] ? MW'(-vy_reg) : MW'(vy_reg);
            // keep the divisor nonzero for points that get discarded
            dv4_reg <= behind ? VW'(1) : vz_reg[VW-1:0];
            m5_reg  <= m4_reg;
            nx_reg  <= NW'(mx_reg) * NW'(pd_reg);
            ny_reg  <= NW'(my_reg) * NW'(pd_reg);
            dv5_reg <= dv4_reg;
        end
    end

    logic           dq_valid;
    epp_pkg::meta_t dq_meta;
    logic [MW-1:0]  qx, qy;

    epp_div #(
        .MW  (MW),
        .DVW (VW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_meta   (m5_reg),
        .num_x     (nx_reg),
        .num_y     (ny_reg),
        .divisor   (dv5_reg),
        .out_valid (dq_valid),
        .out_meta  (dq_meta),
        .quot_x    (qx),
        .quot_y    (qy)
    );

    // final scale, offset and clamp
    function automatic logic signed [epp_pkg::OUT_BITS-1:0] finish(
        input logic [MW-1:0] q,
        input logic          neg,
        input logic [epp_pkg::SCR_BITS-1:0] size
    );
        logic signed [SW-1:0] mag;
        logic signed [SW-1:0] sum;
        logic signed [XW-1:0] sx;
        mag = $signed(SW'(q >> 4));
        if (neg) begin
            mag = -mag;
        end
        sum = mag + $signed(SW'(size >> 1));
        sx  = XW'(sum);
        priority if (sx > XW'(epp_pkg::OUT_MAX)) begin
            finish = epp_pkg::OUT_MAX;
        end else if (sx < XW'(epp_pkg::OUT_MIN)) begin
            finish = epp_pkg::OUT_MIN;
        end else begin
            finish = sx[epp_pkg::OUT_BITS-1:0];
        end
    endfunction

    logic signed [epp_pkg::OUT_BITS-1:0] fx, fy;
    assign fx = dq_meta.behind ? '0 : finish(qx, dq_meta.neg_x, scr_w_reg);
    assign fy = dq_meta.behind ? '0 : finish(qy, dq_meta.neg_y, scr_h_reg);

    // output register plus one skid entry
    logic                                out_valid_reg;
    logic                                out_st_reg, skid_st_reg;
    logic signed [epp_pkg::OUT_BITS-1:0] out_x_reg, out_y_reg, skid_x_reg, skid_y_reg;
    logic                                out_busy;
    assign out_busy = out_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (out_busy) begin
            if (en && dq_valid) begin
                skid_full_reg <= 1'b1;
            end
        end else if (skid_full_reg) begin
            out_valid_reg <= 1'b1;
            skid_full_reg <= 1'b0;
        end else begin
            out_valid_reg <= dq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_busy) begin
            if (en) begin
                skid_st_reg <= dq_meta.behind;
                skid_x_reg  <= fx;
                skid_y_reg  <= fy;
            end
        end else if (skid_full_reg) begin
            out_st_reg <= skid_st_reg;
            out_x_reg  <= skid_x_reg;
            out_y_reg  <= skid_y_reg;
        end else begin
            out_st_reg <= dq_meta.behind;
            out_x_reg  <= fx;
            out_y_reg  <= fy;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_status   = out_st_reg;
    assign m_screen_x = out_x_reg;
    assign m_screen_y = out_y_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_full_reg) |-> $past(out_valid_reg && !m_ready && dq_valid))
        else $error("skid filled without a stalled transfer");

    a_behind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_screen_x == 0 && m_screen_y == 0))
        else $error("point behind the plane carries nonzero coordinates");

    a_frozen_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_full_reg && $past(skid_full_reg)) |-> $stable(qx) && $stable(dq_valid))
        else $error("pipeline moved while frozen");

endmodule
